>>> src/atrsp_pkg.sv
// ----------------------------------------------------------------------------
// atrsp_pkg: shared types, keyword table and helpers
// Request codes, keyword text and incremental keyword matching.
// ----------------------------------------------------------------------------
`default_nettype none

package atrsp_pkg;

   typedef enum logic [1:0] {
      REQ_RX   = 2'd0,
      REQ_POP  = 2'd1,
      REQ_TAKE = 2'd2,
      REQ_ARM  = 2'd3
   } req_type;

   localparam logic [1:0] CMD_IDLE = 2'd0;
   localparam logic [1:0] CMD_OK   = 2'd1;
   localparam logic [1:0] CMD_FAIL = 2'd2;
   localparam logic [1:0] CMD_HELD = 2'd3;

   localparam int KW_COUNT = 15;
   localparam int KW_IPD   = 14;
   localparam int POS_W    = 10;

   typedef logic [KW_COUNT-1:0] kw_flags_type;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [16*8-1:0] KW_TEXT [KW_COUNT] = '{
      {"OK",              112'h0},
      {"SEND OK",          72'h0},
      {"ERROR",            88'h0},
      {"FAIL",             96'h0},
      {"SEND FAIL",        56'h0},
      {"busy",             96'h0},
      {"ready",            88'h0},
      {"WIFI CONNECTED",   16'h0},
      {"WIFI GOT IP",      40'h0},
      {"WIFI DISCONNECT",   8'h0},
      {"CONNECT",          72'h0},
      {"0,CONNECT",        56'h0},
      {"CLOSED",           80'h0},
      {"0,CLOSED",         64'h0},
      {"+IPD,",            88'h0}
   };

   localparam logic [4:0] KW_LEN [KW_COUNT] = '{
      5'd2, 5'd7, 5'd5, 5'd4, 5'd9, 5'd4, 5'd5, 5'd14,
      5'd11, 5'd15, 5'd7, 5'd9, 5'd6, 5'd8, 5'd5
   };

   localparam kw_flags_type KW_PREFIX = 15'b100_0000_0010_0000;

   // text is left aligned: character 0 in the top byte
   function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
      logic [16*8-1:0] t;
      t = KW_TEXT[k];
      return t[(15 - pos)*8 +: 8];
   endfunction

   function automatic kw_flags_type kw_match(input kw_flags_type flags,
                                             input logic [POS_W-1:0] pos,
                                             input logic [7:0] c);
      kw_flags_type f;
      f = flags;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (pos < POS_W'(KW_LEN[k])) begin
            if (kw_char(k, pos[3:0]) != c) f[k] = 1'b0;
         end else if (!KW_PREFIX[k]) begin
            f[k] = 1'b0;
         end
      end
      return f;
   endfunction

   function automatic logic kw_hit(input kw_flags_type flags, input int k,
                                   input logic [POS_W-1:0] len);
      if (!flags[k]) return 1'b0;
      if (KW_PREFIX[k]) return len >= POS_W'(KW_LEN[k]);
      return len == POS_W'(KW_LEN[k]);
   endfunction

endpackage

`default_nettype wire

>>> src/at_response_stream_parser.sv
// ----------------------------------------------------------------------------
// at_response_stream_parser: modem response line parser with payload ring
// Each request item (received byte, pop, take events, arm command) yields
// one response item with the status after that request; a take reports the events it clears.
//
// req channel: tuser = request code, tdata = received byte.
// rsp channel: one item per request, in order.
// The response item of an accepted request is registered in the response
// register; the pop data comes from the ring memory read issued at accept.
// Throughput: one item per cycle while rsp_tready allows; the line state is
// kept in flops and the payload ring in a single one-write, one-read memory
// with registered read. The response register is the output stage: a new
// request is taken while the previous response is taken in the same cycle;
// while rsp_tready stays low the response holds and req_tready drops.
// Reset clears the line state, pointers, events, result and prompt flag.
// The ring contents are not cleared; popped data is only reported once written.
// ----------------------------------------------------------------------------
`default_nettype none

module at_response_stream_parser #(
   parameter int LINE_DEPTH = 128,
   parameter int DATA_DEPTH = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [1:0]  req_tuser,   // [1:0] req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] cmd_result, [2] prompt_seen, [9:3] event_bits, [19:10] data_count,
   // [20] data_valid, [28:21] data_byte, [44:29] payload_pending, [47:45] zero
   output logic [47:0]      rsp_tdata
);

   import atrsp_pkg::*;

   localparam int LW = $clog2(LINE_DEPTH);
   localparam int AW = $clog2(DATA_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DATA_DEPTH - 1);

   logic [LW-1:0]   line_len_ff, line_len_in;
   kw_flags_type    flags_ff, flags_in;
   logic            cr_ff, cr_in;
   logic [15:0]     acc_ff, acc_in;
   logic            dig_ff, dig_in;
   logic [15:0]     remain_ff, remain_in;
   logic [AW-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [6:0]      ev_ff, ev_in;
   logic [1:0]      res_ff, res_in;
   logic            prompt_ff, prompt_in;

   logic            out_valid_ff;
   logic [1:0]      o_res_ff;
   logic            o_prompt_ff;
   logic [6:0]      o_ev_ff;
   logic [9:0]      o_cnt_ff;
   logic            o_pop_ff;
   logic [15:0]     o_remain_ff;
   logic [7:0]      rd_data_ff;

   logic [7:0]      ring_mem [DATA_DEPTH];

   logic            accept;
   req_type         req;
   logic [7:0]      c;
   logic            push, pop_ok;
   logic [AW:0]     cnt_wide;
   logic [19:0]     acc_mul;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign req        = req_type'(req_tuser);
   assign c          = req_tdata;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      return (p == LAST_ADDR) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      logic [POS_W-1:0] pos, len;
      kw_flags_type     f;
      line_len_in = line_len_ff;
      flags_in    = flags_ff;
      cr_in       = cr_ff;
      acc_in      = acc_ff;
      dig_in      = dig_ff;
      remain_in   = remain_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      ev_in       = ev_ff;
      res_in      = res_ff;
      prompt_in   = prompt_ff;
      push        = 1'b0;
      pop_ok      = 1'b0;
      pos         = POS_W'(line_len_ff);
      len         = pos;
      f           = flags_ff;
      acc_mul     = 20'(acc_ff) * 20'd10 + 20'(c - CH_ZERO);
      case (req)
         REQ_RX: begin
            if (remain_ff != 16'd0) begin
               push      = 1'b1;
               head_in   = ptr_next(head_ff);
               if (head_in == tail_ff) tail_in = ptr_next(tail_ff);
               remain_in = remain_ff - 16'd1;
               if (remain_in == 16'd0) ev_in[6] = 1'b1;
            end else if (c == CH_LF) begin
               if (cr_ff && len != '0) len = len - 1'b1;
               if (len != '0) begin
                  if (kw_hit(f, 0, len) || kw_hit(f, 1, len)) res_in = CMD_OK;
                  else if (kw_hit(f, 2, len) || kw_hit(f, 3, len) || kw_hit(f, 4, len))
                     res_in = CMD_FAIL;
                  else if (kw_hit(f, 5, len)) res_in = CMD_HELD;
                  else if (kw_hit(f, 6, len)) ev_in[0] = 1'b1;
                  else if (kw_hit(f, 7, len)) ev_in[1] = 1'b1;
                  else if (kw_hit(f, 8, len)) ev_in[2] = 1'b1;
                  else if (kw_hit(f, 9, len)) ev_in[3] = 1'b1;
                  else if (kw_hit(f, 10, len) || kw_hit(f, 11, len)) ev_in[4] = 1'b1;
                  else if (kw_hit(f, 12, len) || kw_hit(f, 13, len)) ev_in[5] = 1'b1;
               end
               line_len_in = '0;
               flags_in    = '1;
               cr_in       = 1'b0;
               acc_in      = '0;
               dig_in      = 1'b0;
            end else if (pos >= POS_W'(LINE_DEPTH - 1)) begin
               line_len_in = '0;
               flags_in    = '1;
               cr_in       = 1'b0;
               acc_in      = '0;
               dig_in      = 1'b0;
            end else begin
               if (cr_ff && pos != '0) f = kw_match(f, pos - 1'b1, CH_CR);
               cr_in = (c == CH_CR);
               if (c != CH_CR) f = kw_match(f, pos, c);
               flags_in = f;
               if (c == CH_COMMA) begin
                  acc_in = '0;
                  dig_in = 1'b1;
               end else if (dig_ff && c >= CH_ZERO && c <= CH_NINE) begin
                  acc_in = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[15:0];
               end else begin
                  dig_in = 1'b0;
               end
               line_len_in = line_len_ff + 1'b1;
               if (pos == '0 && c == CH_GT) begin
                  prompt_in   = 1'b1;
                  line_len_in = '0;
                  flags_in    = '1;
                  cr_in       = 1'b0;
                  acc_in      = '0;
                  dig_in      = 1'b0;
               end else if (c == CH_COLON && f[KW_IPD]) begin
                  if (acc_in != 16'd0) remain_in = acc_in;
                  line_len_in = '0;
                  flags_in    = '1;
                  cr_in       = 1'b0;
                  acc_in      = '0;
                  dig_in      = 1'b0;
               end
            end
         end
         REQ_POP: begin
            if (tail_ff != head_ff) begin
               pop_ok  = 1'b1;
               tail_in = ptr_next(tail_ff);
            end
         end
         REQ_TAKE: ev_in = '0;
         REQ_ARM: begin
            res_in    = CMD_IDLE;
            prompt_in = 1'b0;
         end
         default: ;
      endcase
      cnt_wide = (head_in >= tail_in) ? {1'b0, head_in} - {1'b0, tail_in}
                                       : {1'b0, head_in} + (AW+1)'(DATA_DEPTH)
                                         - {1'b0, tail_in};
   end

   always_ff @(posedge clock) begin
      if (accept && push) ring_mem[head_ff] <= c;
      if (accept) rd_data_ff <= ring_mem[tail_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_len_ff  <= '0;
         flags_ff     <= '1;
         cr_ff        <= 1'b0;
         acc_ff       <= '0;
         dig_ff       <= 1'b0;
         remain_ff    <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         ev_ff        <= '0;
         res_ff       <= CMD_IDLE;
         prompt_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         o_pop_ff     <= 1'b0;
      end else begin
         if (rsp_tready) out_valid_ff <= 1'b0;
         if (accept) begin
            line_len_ff  <= line_len_in;
            flags_ff     <= flags_in;
            cr_ff        <= cr_in;
            acc_ff       <= acc_in;
            dig_ff       <= dig_in;
            remain_ff    <= remain_in;
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            ev_ff        <= ev_in;
            res_ff       <= res_in;
            prompt_ff    <= prompt_in;
            out_valid_ff <= 1'b1;
            o_pop_ff     <= pop_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         o_res_ff    <= res_in;
         o_prompt_ff <= prompt_in;
         o_ev_ff     <= (req == REQ_TAKE) ? ev_ff : ev_in;
         o_cnt_ff    <= 10'(cnt_wide);
         o_remain_ff <= remain_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, o_remain_ff, (o_pop_ff ? rd_data_ff : 8'h00), o_pop_ff,
                        o_cnt_ff, o_ev_ff, o_prompt_ff, o_res_ff};

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      accept && req == REQ_POP && head_ff == tail_ff |=> !o_pop_ff)
      else $error("pop from empty ring reported data");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      accept && req == REQ_RX && remain_ff != 16'd0 |=> remain_ff == $past(remain_ff) - 16'd1)
      else $error("payload count did not step");

   a_arm_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req == REQ_ARM |=> res_ff == CMD_IDLE && !prompt_ff)
      else $error("arm did not clear result and prompt");

endmodule

`default_nettype wire

>>> sim/at_response_stream_parser_tb.sv
// ----------------------------------------------------------------------------
// at_response_stream_parser_tb: self-checking bench for the response parser
// Drives request items (bytes, pops, takes, arms) with random gaps on both
// streams, predicts each response item and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module at_response_stream_parser_tb;
   import atrsp_pkg::*;

   localparam int LINE_LIM  = 128;
   localparam int RING_SIZE = 1024;
   localparam int NUM_KW    = 15;
   localparam int MAX_CYC   = 400000;

   typedef struct packed {
      logic [15:0] pending;
      logic [7:0]  dbyte;
      logic        dvalid;
      logic [9:0]  count;
      logic [6:0]  events;
      logic        prompt;
      logic [1:0]  result;
   } status_type;

   class parser_scoreboard;
      string       kw_text [NUM_KW];
      bit          kw_pfx [NUM_KW];
      int          line_len;
      bit [15:0]   flags;
      bit          pend_cr;
      int          len_acc;
      bit          digits_on;
      int          remaining;
      logic [7:0]  ring [RING_SIZE];
      int          head, tail;
      bit [6:0]    events;
      logic [1:0]  result;
      bit          prompt;
      status_type  expected_q[$];
      int          mismatches;
      int          checked;

      function new();
         kw_text = '{"OK", "SEND OK", "ERROR", "FAIL", "SEND FAIL", "busy", "ready",
                     "WIFI CONNECTED", "WIFI GOT IP", "WIFI DISCONNECT", "CONNECT",
                     "0,CONNECT", "CLOSED", "0,CLOSED", "+IPD,"};
         foreach (kw_pfx[k]) kw_pfx[k] = (k == 5 || k == KW_IPD);
         clear_line();
         remaining = 0; head = 0; tail = 0; events = 0;
         result = CMD_IDLE; prompt = 0; mismatches = 0; checked = 0;
      endfunction

      function void clear_line();
         line_len = 0; flags = 16'hFFFF; pend_cr = 0; len_acc = 0; digits_on = 0;
      endfunction

      function void match(int pos, byte unsigned c);
         for (int k = 0; k < NUM_KW; k++) begin
            if (!flags[k]) continue;
            if (pos < kw_text[k].len()) begin
               if (kw_text[k][pos] != c) flags[k] = 0;
            end else if (!kw_pfx[k]) flags[k] = 0;
         end
      endfunction

      function bit hit(int k, int n);
         if (!flags[k]) return 0;
         return kw_pfx[k] ? (n >= kw_text[k].len()) : (n == kw_text[k].len());
      endfunction

      function void finish_line(int n);
         if (hit(0, n) || hit(1, n)) result = CMD_OK;
         else if (hit(2, n) || hit(3, n) || hit(4, n)) result = CMD_FAIL;
         else if (hit(5, n)) result = CMD_HELD;
         else if (hit(6, n)) events[0] = 1;
         else if (hit(7, n)) events[1] = 1;
         else if (hit(8, n)) events[2] = 1;
         else if (hit(9, n)) events[3] = 1;
         else if (hit(10, n) || hit(11, n)) events[4] = 1;
         else if (hit(12, n) || hit(13, n)) events[5] = 1;
      endfunction

      function void rx(byte unsigned c);
         int pos, n;
         if (remaining > 0) begin
            if ((head + 1) % RING_SIZE == tail) tail = (tail + 1) % RING_SIZE;
            ring[head] = c;
            head = (head + 1) % RING_SIZE;
            remaining--;
            if (remaining == 0) events[6] = 1;
            return;
         end
         if (c == CH_LF) begin
            n = line_len;
            if (pend_cr && n > 0) n--;
            if (n > 0) finish_line(n);
            clear_line();
            return;
         end
         if (line_len >= LINE_LIM - 1) begin
            clear_line();
            return;
         end
         pos = line_len;
         if (pend_cr && pos > 0) match(pos - 1, CH_CR);
         pend_cr = (c == CH_CR);
         if (!pend_cr) match(pos, c);
         if (c == CH_COMMA) begin
            len_acc = 0; digits_on = 1;
         end else if (digits_on && c >= CH_ZERO && c <= CH_NINE) begin
            len_acc = len_acc * 10 + (c - CH_ZERO);
            if (len_acc > 65535) len_acc = 65535;
         end else digits_on = 0;
         line_len = pos + 1;
         if (line_len == 1 && c == CH_GT) begin
            prompt = 1;
            clear_line();
            return;
         end
         if (c == CH_COLON && flags[KW_IPD]) begin
            if (len_acc > 0) remaining = len_acc;
            clear_line();
         end
      endfunction

      function void note_request(req_type rq, logic [7:0] b);
         status_type s;
         s = '0;
         case (rq)
            REQ_RX: rx(b);
            REQ_POP: begin
               if (tail != head) begin
                  s.dvalid = 1; s.dbyte = ring[tail];
                  tail = (tail + 1) % RING_SIZE;
               end
            end
            REQ_ARM: begin
               result = CMD_IDLE; prompt = 0;
            end
            default: ;
         endcase
         s.events = events;
         if (rq == REQ_TAKE) events = 0;
         s.result = result;
         s.prompt = prompt;
         s.count = 10'((head + RING_SIZE - tail) % RING_SIZE);
         s.pending = 16'(remaining);
         expected_q.push_back(s);
      endfunction

      function void check_response(logic [47:0] d);
         status_type got, exp_s;
         got = d[44:0];
         checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response item %h", d);
            return;
         end
         exp_s = expected_q.pop_front();
         if (got !== exp_s || d[47:45] !== 3'b000) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch item %0d: exp res=%0d pr=%0d ev=%h cnt=%0d v=%0d b=%h pend=%0d",
                  checked, exp_s.result, exp_s.prompt, exp_s.events, exp_s.count,
                  exp_s.dvalid, exp_s.dbyte, exp_s.pending);
               $display("   got res=%0d pr=%0d ev=%h cnt=%0d v=%0d b=%h pend=%0d",
                  got.result, got.prompt, got.events, got.count, got.dvalid,
                  got.dbyte, got.pending);
            end
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;
   logic [1:0]  req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;

   parser_scoreboard sb;
   int  send_idle_pct = 34;
   int  recv_idle_pct = 70;
   int  stall_len = 0;
   int  stall_cnt = 0;
   bit  stall_done = 0;
   int  cycle_count = 0;
   int  rx_items = 0;
   int  req_items = 0;

   always #5 clock = ~clock;

   at_response_stream_parser dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYC) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("at_response_stream_parser_tb NOT OK");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      if (stall_len > 0 && !stall_done) begin
         rsp_tready <= 0;
         stall_cnt  <= stall_cnt + 1;
         if (stall_cnt + 1 >= stall_len) stall_done <= 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send(req_type rq, logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= rq;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(rq, b);
      req_items++;
      if (rq == REQ_RX) rx_items++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send(REQ_RX, s[i]);
   endtask

   task automatic send_line(string s);
      send_text(s);
      send(REQ_RX, CH_CR);
      send(REQ_RX, CH_LF);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_burst(int count);
      string lines [16];
      int    n;
      lines = '{"OK", "SEND OK", "ERROR", "FAIL", "SEND FAIL", "busy p...", "ready",
                "WIFI CONNECTED", "WIFI GOT IP", "WIFI DISCONNECT", "CONNECT",
                "0,CONNECT", "CLOSED", "0,CLOSED", "OKX", "SEND"};
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0, 1, 2: send_line(lines[$urandom_range(15)]);
            3: begin
               n = $urandom_range(1, 12);
               send_text($sformatf("+IPD,%0d,%0d:", $urandom_range(4), n));
               repeat (n) send(REQ_RX, 8'($urandom_range(255)));
            end
            4: send(REQ_RX, 8'($urandom_range(255)));
            5, 6: send(REQ_POP, 8'($urandom_range(255)));
            7: send(REQ_TAKE, 8'($urandom_range(255)));
            8: send(REQ_ARM, 8'($urandom_range(255)));
            default: begin
               send(REQ_ARM, 8'h00);
               send_text(">");
               send_line(($urandom_range(1)) ? "OK" : "ERR");
            end
         endcase
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      send(REQ_POP, 8'h00);
      send_line("OK");
      send(REQ_ARM, 8'hFF);
      send_text(">");
      send_line("ERROR");
      send_text("busy s\n");
      send_line("ready");
      send_text("\r\n");
      send_text("O\rK\n");
      send(REQ_RX, 8'h00);
      send(REQ_RX, CH_LF);
      send_line("WIFI GOT IP");
      send(REQ_TAKE, 8'h00);
      send_text("+IPD,0:");
      send_text("+IPD,0,3:");
      send_text("a\r\n");
      for (int i = 0; i < 130; i++) send(REQ_RX, 8'h41);
      send_line("OK");
      drain();

      // long receiver stall while requests pile up
      stall_len = 200;
      repeat (30) send(REQ_POP, 8'h00);
      drain();

      random_burst(20);
      drain();
      send_idle_pct = 70; recv_idle_pct = 34;
      random_burst(20);
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      random_burst(20);
      // saturated payload length, then a few payload bytes and pops
      send(REQ_RX, CH_LF);
      send_text("+IPD,99999:");
      repeat (30) send(REQ_RX, 8'($urandom_range(255)));
      repeat (20) send(REQ_POP, 8'h00);
      drain();
      repeat (20) @(posedge clock);

      $display("covered %0d requests (%0d received bytes), %0d responses checked",
               req_items, rx_items, sb.checked);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("at_response_stream_parser_tb OK");
      else begin
         $display("%0d mismatches, %0d responses missing", sb.mismatches,
                  sb.expected_q.size());
         $display("at_response_stream_parser_tb NOT OK");
      end
      $finish;
   end
endmodule

`default_nettype wire

>>> filelist.f
src/atrsp_pkg.sv
src/at_response_stream_parser.sv
sim/at_response_stream_parser_tb.sv
